>>> rtl/osdsb_pkg.sv
`timescale 1ns / 1ps

package osdsb_pkg;

  localparam int NUM_SLOTS   = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int OP_W        = 2;
  localparam int SLOT_W      = 8;
  localparam int CYCLE_W     = 32;
  localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

  localparam logic [OP_W-1:0] OP_POLL   = 2'd0;
  localparam logic [OP_W-1:0] OP_DISARM = 2'd1;
  localparam logic [OP_W-1:0] OP_EXPIRE = 2'd2;

  localparam logic [CYCLE_W-1:0] COUNT_MAX =
    CYCLE_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [IDX_W-1:0]       slot_idx_t;

  typedef struct packed {
    logic expired;
    logic start_event;
    logic finish_event;
  } result_t;

endpackage

>>> rtl/osdsb_slot_bank.sv
`timescale 1ns / 1ps

module osdsb_slot_bank (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [osdsb_pkg::OP_W-1:0]    op_i,
  input  logic [osdsb_pkg::SLOT_W-1:0]  slot_id_i,
  input  logic [osdsb_pkg::CYCLE_W-1:0] cycle_count_i,
  output logic                    busy_o,
  output logic                    res_valid_o,
  output osdsb_pkg::result_t      res_o
);
  import osdsb_pkg::*;

  logic [NUM_SLOTS-1:0] armed_q;
  count_t               count_mem [NUM_SLOTS];

  logic                 s1_valid_q;
  logic [OP_W-1:0]      s1_op_q;
  slot_idx_t            s1_idx_q;
  logic                 s1_in_range_q;
  logic [CYCLE_W-1:0]   s1_cycles_q;
  count_t               rd_q;
  logic                 fwd_hit_q;
  count_t               fwd_q;

  slot_idx_t            in_idx;
  logic                 in_range;
  count_t               cur_count;
  logic [CYCLE_W-1:0]   cyc_dec;
  count_t               load_val;
  logic                 cur_armed;
  logic                 cnt_we;
  count_t               cnt_wdata;
  logic                 arm_we;
  logic                 arm_wdata;
  result_t              res;

  assign in_idx   = IDX_W'(slot_id_i);
  assign in_range = (32'(slot_id_i) < NUM_SLOTS);

  assign cur_count = fwd_hit_q ? fwd_q : rd_q;
  assign cur_armed = armed_q[s1_idx_q];
  assign cyc_dec   = (s1_cycles_q != '0) ? (s1_cycles_q - CYCLE_W'(1)) : '0;
  assign load_val  = (cyc_dec > COUNT_MAX) ? '1 : COUNT_WIDTH'(cyc_dec);

  always_comb begin
    cnt_we    = 1'b0;
    cnt_wdata = '0;
    arm_we    = 1'b0;
    arm_wdata = 1'b0;
    res       = '0;
    if (s1_valid_q && s1_in_range_q) begin
      case (s1_op_q)
        OP_POLL: begin
          if (!cur_armed) begin
            arm_we          = 1'b1;
            arm_wdata       = 1'b1;
            cnt_we          = 1'b1;
            cnt_wdata       = load_val;
            res.start_event = 1'b1;
          end else if (cur_count != '0) begin
            cnt_we    = 1'b1;
            cnt_wdata = cur_count - COUNT_WIDTH'(1);
          end else begin
            res.expired      = 1'b1;
            res.finish_event = 1'b1;
          end
        end
        OP_DISARM: begin
          arm_we    = 1'b1;
          arm_wdata = 1'b0;
        end
        OP_EXPIRE: begin
          arm_we    = 1'b1;
          arm_wdata = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = '0;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
      if (arm_we) begin
        armed_q[s1_idx_q] <= arm_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      count_mem[s1_idx_q] <= cnt_wdata;
    end
    if (accept_i) begin
      rd_q          <= count_mem[in_idx];
      fwd_hit_q     <= cnt_we && (s1_idx_q == in_idx);
      fwd_q         <= cnt_wdata;
      s1_op_q       <= op_i;
      s1_idx_q      <= in_idx;
      s1_in_range_q <= in_range;
      s1_cycles_q   <= cycle_count_i;
    end
  end

  assign busy_o      = s1_valid_q;
  assign res_valid_o = s1_valid_q;
  assign res_o       = res;

endmodule

>>> rtl/osdsb_out_fifo.sv
`timescale 1ns / 1ps

module osdsb_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  osdsb_pkg::result_t            push_data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output osdsb_pkg::result_t            data_o,
  output logic [osdsb_pkg::FIFO_CNT_W-1:0] count_o
);
  import osdsb_pkg::*;

  result_t                buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q;
  logic [FIFO_PTR_W-1:0]  rd_ptr_q;
  logic [FIFO_CNT_W-1:0]  cnt_q;
  logic                   do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + FIFO_CNT_W'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/one_shot_delay_slot_bank_core.sv
`timescale 1ns / 1ps

// Bank of one-shot delay slots, each an armed bit plus a down-counter.
// Request channel: in_valid_i / in_stall_o with op_i, slot_id_i and
// cycle_count_i. A request is taken at a rising edge with in_valid_i high
// and in_stall_o low. Poll arms an idle slot (start_event_o), counts an armed
// slot down, and reports expired_o / finish_event_o once it reaches zero.
// Disarm clears a slot; expire arms it at zero.
// Result channel: out_valid_o / out_stall_i with expired_o, start_event_o and
// finish_event_o; exactly one result per request, in request order.
// A request is registered in the bank's stage 1; its result is then queued.
// Throughput: one request per cycle while in_stall_o is low, set by the single
// count-memory read-modify-write with a one-entry bypass for back-to-back hits.
// A stalled receiver fills a four-entry result queue; once it and the request
// in flight would fill it, in_stall_o rises and stays high until results drain.
// Reset disarms every slot and empties the queue; no clearing pass is needed
// because a count is only used on an armed slot.
module one_shot_delay_slot_bank_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [osdsb_pkg::OP_W-1:0]      op_i,
  input  logic [osdsb_pkg::SLOT_W-1:0]    slot_id_i,
  input  logic [osdsb_pkg::CYCLE_W-1:0]   cycle_count_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            expired_o,
  output logic                            start_event_o,
  output logic                            finish_event_o
);
  import osdsb_pkg::*;

  logic                  accept;
  logic                  busy;
  logic                  res_valid;
  result_t               res;
  result_t               head;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_CNT_W:0]   pending;

  assign pending    = {1'b0, fifo_cnt} + (FIFO_CNT_W + 1)'(busy);
  assign in_stall_o = (pending >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  osdsb_slot_bank u_bank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (op_i),
    .slot_id_i     (slot_id_i),
    .cycle_count_i (cycle_count_i),
    .busy_o        (busy),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  osdsb_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (!out_stall_i),
    .valid_o     (out_valid_o),
    .data_o      (head),
    .count_o     (fifo_cnt)
  );

  assign expired_o      = head.expired;
  assign start_event_o  = head.start_event;
  assign finish_event_o = head.finish_event;

endmodule
